[hdl/kwl_pkg.sv]
// Keyword token lexer package: result record, token type codes, characters,
// the keyword table and its lookup function. No dependencies.
package kwl_pkg;

  localparam int MAX_KW_LEN = 10;
  localparam int KW_COUNT   = 74;
  localparam int KW_BITS    = 8 * MAX_KW_LEN;
  localparam int QDEPTH     = 4;

  localparam logic [1:0] K_TEXT  = 2'd0;
  localparam logic [1:0] K_CLOSE = 2'd1;
  localparam logic [1:0] K_ERR   = 2'd2;

  localparam logic [6:0] TT_VARCHAR = 7'd86;
  localparam logic [6:0] TT_INT     = 7'd40;
  localparam logic [6:0] TT_FLOAT   = 7'd35;
  localparam logic [6:0] TT_DOT     = 7'd27;
  localparam logic [6:0] TT_END     = 7'd88;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_APOS   = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;

  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] token_type;
    logic [7:0] text_char;
    logic       last;
  } res_t;

  typedef struct packed {
    res_t       r0;
    res_t       r1;
    logic [1:0] cnt;
  } push_t;

  localparam logic [KW_BITS-1:0] KW_TXT [KW_COUNT] = '{
    "ADD", "ADDCLMN", "ADDFGNKEY", "ADDNDX", "ALTUSR", "AND", "CALL", "CHAR",
    "CMPEQ", "CMPGE", "CMPGT", "CMPLE", "CMPLT", "CMPNE", "CRJOIN", "CRTDB",
    "CRTTBL", "CRTUSR", "DATA", "DELETE", "DESCRIBE", "DIV", "DROPCLMN",
    "DROPDB", "DROPFGNKEY", "DROPNDX", "DROPTBL", "DROPUSR", "FLOAT", "GRANT",
    "INJOIN", "INSERT", "INT", "LOADDATA", "LTJOIN", "MKASSIGN", "MKASTEXPR",
    "MKCLMNDEF", "MKCLMNEXPR", "MKEXPR", "MKEXPRHDR", "MKEXPRLST", "MKFGNKEY",
    "MKPRIKEY", "MKUNIKEY", "MKUSR", "MKWRKSCH", "MUL", "NEGATE", "NOP", "NOT",
    "ON", "OPNTBL", "OR", "ORDERBY", "PRIMARY", "PUSH", "PUSHO", "RET",
    "REVOKE", "RTJOIN", "SELECT", "SETOUTF", "SHOWDBS", "SHOWTBLS", "SLCKTBL",
    "SUB", "TEXT", "ULCKTBL", "UPDATE", "USE", "USING", "VARCHAR", "WHERE"
  };

  localparam logic [6:0] KW_TYPE [KW_COUNT] = '{
    7'd0, 7'd1, 7'd2, 7'd3, 7'd5, 7'd6, 7'd9, 7'd10,
    7'd12, 7'd13, 7'd14, 7'd15, 7'd16, 7'd17, 7'd18, 7'd19,
    7'd20, 7'd21, 7'd22, 7'd23, 7'd24, 7'd25, 7'd29,
    7'd30, 7'd31, 7'd32, 7'd33, 7'd34, 7'd35, 7'd36,
    7'd38, 7'd39, 7'd40, 7'd41, 7'd42, 7'd45, 7'd46,
    7'd47, 7'd48, 7'd49, 7'd50, 7'd51, 7'd52,
    7'd53, 7'd54, 7'd55, 7'd56, 7'd57, 7'd58, 7'd59, 7'd60,
    7'd61, 7'd62, 7'd63, 7'd64, 7'd67, 7'd68, 7'd69, 7'd72,
    7'd73, 7'd74, 7'd75, 7'd76, 7'd77, 7'd78, 7'd79,
    7'd80, 7'd81, 7'd82, 7'd83, 7'd84, 7'd85, 7'd86, 7'd87
  };

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) ? c - 8'd32 : c;
  endfunction

  // word holds the name packed first char highest, zero above; names never hold 0
  function automatic logic [6:0] kw_lookup(input logic [KW_BITS-1:0] word,
                                           input logic [3:0] len);
    logic [6:0] t;
    t = TT_VARCHAR;
    for (int i = 0; i < KW_COUNT; i++) begin
      if (word == KW_TXT[i]) t = KW_TYPE[i];
    end
    if (len > 4'(MAX_KW_LEN)) t = TT_VARCHAR;
    return t;
  endfunction

endpackage

[hdl/kwl_front.sv]
// Lexer front: accepts characters, runs the mode state machine and the
// keyword match, and pushes zero to two results. Depends on kwl_pkg.
module kwl_front import kwl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       acc,
  input  logic [7:0] in_char,
  input  logic       end_of_input,
  output push_t      push
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_WS   = 9'b000000010,
    S_NAME = 9'b000000100,
    S_INT  = 9'b000001000,
    S_FRAC = 9'b000010000,
    S_DOT  = 9'b000100000,
    S_STR  = 9'b001000000,
    S_ESC  = 9'b010000000,
    S_ERR  = 9'b100000000
  } mode_t;

  mode_t              mode, mode_next, st_mode;
  logic [KW_BITS-1:0] word;
  logic [3:0]         name_length;
  logic [7:0]         c;
  logic               st_v, st_name, pv, add_name, clr_len;
  res_t               st_r, p, r0, r1;
  logic [1:0]         n;

  function automatic res_t mk(input logic [1:0] k, input logic [6:0] t,
                              input logic [7:0] ch);
    res_t r;
    r.kind = k;
    r.token_type = t;
    r.text_char = ch;
    r.last = 1'b0;
    return r;
  endfunction

  assign c = in_char;

  always_comb begin
    st_mode = S_IDLE;
    st_v = 1'b0;
    st_name = 1'b0;
    st_r = mk(K_CLOSE, 7'd0, c);
    case (c)
      CH_SPACE, CH_TAB, CH_LF: st_mode = S_WS;
      CH_QUOTE, CH_BSLASH: st_mode = S_STR;
      CH_HASH: begin st_v = 1'b1; st_r.token_type = 7'd37; end
      CH_DOLLAR: begin st_v = 1'b1; st_r.token_type = 7'd26; end
      CH_PCT: begin st_v = 1'b1; st_r.token_type = 7'd65; end
      CH_APOS: begin st_v = 1'b1; st_r.token_type = 7'd70; end
      CH_LPAREN: begin st_v = 1'b1; st_r.token_type = 7'd43; end
      CH_RPAREN: begin st_v = 1'b1; st_r.token_type = 7'd71; end
      CH_STAR: begin st_v = 1'b1; st_r.token_type = 7'd7; end
      CH_PLUS: begin st_v = 1'b1; st_r.token_type = 7'd66; end
      CH_COMMA: begin st_v = 1'b1; st_r.token_type = 7'd11; end
      CH_DOT: st_mode = S_DOT;
      default: begin
        st_v = 1'b1;
        if (is_alpha(c) || c == CH_UNDER) begin
          st_name = 1'b1;
          st_mode = S_NAME;
          st_r = mk(K_TEXT, 7'd0, c);
        end else if (is_digit(c) || c == CH_MINUS) begin
          st_mode = S_INT;
          st_r = mk(K_TEXT, 7'd0, c);
        end else begin
          st_mode = S_ERR;
          st_r = mk(K_ERR, 7'd0, c);
        end
      end
    endcase
  end

  always_comb begin
    mode_next = mode;
    pv = 1'b0;
    p = mk(K_CLOSE, 7'd0, 8'd0);
    r0 = mk(K_TEXT, 7'd0, c);
    r1 = st_r;
    n = 2'd0;
    add_name = 1'b0;
    clr_len = 1'b0;
    if (end_of_input) begin
      case (mode)
        S_NAME: begin pv = 1'b1; p.token_type = kw_lookup(word, name_length); end
        S_INT: begin pv = 1'b1; p.token_type = TT_INT; end
        S_FRAC: begin pv = 1'b1; p.token_type = TT_FLOAT; end
        S_DOT: begin pv = 1'b1; p.token_type = TT_DOT; p.text_char = CH_DOT; end
        S_STR, S_ESC: begin pv = 1'b1; p.token_type = TT_VARCHAR; end
        default: pv = 1'b0;
      endcase
      r1 = mk(K_CLOSE, TT_END, 8'd0);
      if (pv) begin
        r0 = p;
        n = 2'd2;
      end else begin
        r0 = r1;
        n = 2'd1;
      end
      mode_next = S_IDLE;
      clr_len = 1'b1;
    end else begin
      case (mode)
        S_WS: if (!is_space(c)) pv = 1'b1;
        S_NAME: begin
          if (is_alpha(c) || is_digit(c) || c == CH_UNDER) begin
            add_name = 1'b1;
            n = 2'd1;
          end else begin
            pv = 1'b1;
            p.token_type = kw_lookup(word, name_length);
          end
        end
        S_INT: begin
          if (is_digit(c)) begin
            n = 2'd1;
          end else if (c == CH_DOT) begin
            n = 2'd1;
            mode_next = S_FRAC;
          end else begin
            pv = 1'b1;
            p.token_type = TT_INT;
          end
        end
        S_FRAC: begin
          if (is_digit(c)) n = 2'd1;
          else begin
            pv = 1'b1;
            p.token_type = TT_FLOAT;
          end
        end
        S_DOT: begin
          if (is_digit(c)) begin
            r0 = mk(K_TEXT, 7'd0, CH_DOT);
            r1 = mk(K_TEXT, 7'd0, c);
            n = 2'd2;
            mode_next = S_FRAC;
          end else begin
            pv = 1'b1;
            p.token_type = TT_DOT;
            p.text_char = CH_DOT;
          end
        end
        S_STR: begin
          if (c == CH_BSLASH) begin
            n = 2'd1;
            mode_next = S_ESC;
          end else if (c == CH_QUOTE) begin
            r0 = mk(K_CLOSE, TT_VARCHAR, 8'd0);
            n = 2'd1;
            mode_next = S_IDLE;
          end else n = 2'd1;
        end
        S_ESC: begin
          n = 2'd1;
          mode_next = S_STR;
        end
        S_ERR: n = 2'd0;
        default: pv = 1'b1;
      endcase
      // pv here means a start of a new token, with a pending close unless idle/ws
      if (pv) begin
        mode_next = st_mode;
        if (mode == S_WS || mode == S_IDLE) begin
          r0 = st_r;
          n = {1'b0, st_v};
        end else begin
          r0 = p;
          n = st_v ? 2'd2 : 2'd1;
        end
      end
    end
  end

  always_comb begin
    push.r0 = r0;
    push.r1 = r1;
    push.cnt = acc ? n : 2'd0;
    if (n == 2'd1) push.r0.last = 1'b1;
    if (n == 2'd2) push.r1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= S_IDLE;
      name_length <= '0;
    end else if (acc) begin
      mode <= mode_next;
      if (clr_len) name_length <= '0;
      else if (pv && st_name) begin
        name_length <= 4'd1;
        word <= {{(KW_BITS-8){1'b0}}, to_upper(c)};
      end else if (add_name) begin
        if (name_length < 4'(MAX_KW_LEN)) word <= {word[KW_BITS-9:0], to_upper(c)};
        if (name_length <= 4'(MAX_KW_LEN)) name_length <= name_length + 4'd1;
      end
    end
  end

  a_eoi_emits: assert property (@(posedge clk) disable iff (rst)
    (acc && end_of_input) |-> (push.cnt != 2'd0)) else $error("end token missing");

  a_len_sat: assert property (@(posedge clk) disable iff (rst)
    name_length <= 4'(MAX_KW_LEN + 1)) else $error("name length overflow");

  a_err_quiet: assert property (@(posedge clk) disable iff (rst)
    (acc && !end_of_input && mode == S_ERR) |-> (push.cnt == 2'd0))
    else $error("output in error state");

endmodule

[hdl/kwl_queue.sv]
// Result queue between lexer front and output port: takes up to two
// results per cycle, hands out one. Depends on kwl_pkg.
module kwl_queue import kwl_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  push_t push,
  output logic  space2,
  output logic  out_valid,
  input  logic  out_ready,
  output res_t  head
);

  localparam int AW = $clog2(QDEPTH);

  res_t          mem [QDEPTH];
  logic [AW-1:0] wptr, rptr;
  logic [AW:0]   count;
  logic          pop;

  assign pop = out_valid && out_ready;
  assign out_valid = count != '0;
  assign space2 = count <= (AW+1)'(QDEPTH - 2);
  assign head = mem[rptr];

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) mem[wptr] <= push.r0;
    if (push.cnt == 2'd2) mem[wptr + AW'(1)] <= push.r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      wptr <= wptr + AW'(push.cnt);
      if (pop) rptr <= rptr + AW'(1);
      count <= count + (AW+1)'(push.cnt) - (AW+1)'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push.cnt != 2'd0) |-> space2) else $error("push into full queue");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> count == $past(count) + (AW+1)'($past(push.cnt)) - (AW+1)'($past(pop)))
    else $error("queue count mismatch");

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= (AW+1)'(QDEPTH)) else $error("queue count above depth");

endmodule

[hdl/keyword_token_lexer.sv]
// Keyword token lexer top level: lexer front feeding a result queue.
// Depends on kwl_pkg, kwl_front, kwl_queue.
//
// Input channel (in_valid/in_ready): one character request per cycle while
// in_ready is high; end_of_input flushes the pending token and emits the
// end token (type 88). Output channel (out_valid/out_ready): one result per
// cycle while out_ready is high: kind 0 is a token text character, 1 a
// token close with token_type, 2 an error. last_of_run marks the final
// result of one input request. A result is registered into the queue
// when its character is accepted and waits behind earlier results.
// Throughput: one character per cycle while each yields at most one result
// and out_ready stays high; two-result characters fill the 4-deep queue.
// in_ready is high while the queue has room for two results, so the front
// keeps taking characters while earlier results wait at the output.
// Keyword matching compares the name word against all 74 table entries in
// parallel at the close of a name.
// Reset clears the lexer mode, name length and queue; nothing is output.
// A stalled receiver: in_ready drops once under two queue entries are free.
module keyword_token_lexer import kwl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char,
  input  logic       end_of_input,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] kind,
  output logic [6:0] token_type,
  output logic [7:0] text_char,
  output logic       last_of_run
);

  push_t push;
  res_t  head;
  logic  acc;

  assign acc = in_valid && in_ready;

  kwl_front u_front (
    .clk          (clk),
    .rst          (rst),
    .acc          (acc),
    .in_char      (in_char),
    .end_of_input (end_of_input),
    .push         (push)
  );

  kwl_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .space2    (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign kind = head.kind;
  assign token_type = head.token_type;
  assign text_char = head.text_char;
  assign last_of_run = head.last;

endmodule
